// ===== rtl/abr_sra_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ABR source rate adjust package
// Widths, opcodes, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
package abr_sra_pkg;

    localparam int RATE_W   = 27;
    localparam int CNT_W    = 20;
    localparam int SLOT_W   = 32;
    localparam int SHIFT_W  = 4;
    localparam int IVAL_W   = 30;
    localparam int FRAC_W   = 8;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_CONNECT = 2'd0;
    localparam logic [OP_W-1:0] OP_BRM     = 2'd1;
    localparam logic [OP_W-1:0] OP_SENT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_RATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_SHIFT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEC_SHIFT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CRM       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIM  = 3'd7;

    localparam logic [RATE_W-1:0]  RST_MIN_RATE  = 27'd51200;
    localparam logic [RATE_W-1:0]  RST_PEAK_RATE = 27'd204800;
    localparam logic [RATE_W-1:0]  RST_INIT_RATE = 27'd204800;
    localparam logic [RATE_W-1:0]  RST_LINK_RATE = 27'd90421133;
    localparam logic [SHIFT_W-1:0] RST_INC_SHIFT = 4'd4;
    localparam logic [SHIFT_W-1:0] RST_DEC_SHIFT = 4'd4;
    localparam logic [CNT_W-1:0]   RST_CRM       = 20'd524287;
    localparam logic [SLOT_W-1:0]  RST_IDLE_LIM  = 32'd176604;

    localparam logic [SHIFT_W-1:0] CDF_SHIFT     = 4'd4;
    localparam logic [RATE_W-1:0]  STOP_RATE     = 27'd2560;
    localparam logic [IVAL_W-1:0]  SAT_INTERVAL  = 30'd1000000000;

    typedef struct packed {
        logic [RATE_W-1:0]  min_rate;
        logic [RATE_W-1:0]  peak_rate;
        logic [RATE_W-1:0]  initial_rate;
        logic [RATE_W-1:0]  link_rate;
        logic [SHIFT_W-1:0] increase_shift;
        logic [SHIFT_W-1:0] decrease_shift;
        logic [CNT_W-1:0]   missing_rm_limit;
        logic [SLOT_W-1:0]  idle_limit_ticks;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic              cong_ind;
        logic              no_increase;
        logic              backward_notice;
        logic [RATE_W-1:0] explicit_rate;
        logic [SLOT_W-1:0] now_slot;
    } t_item;

    typedef struct packed {
        logic phase_a;
        logic phase_b;
    } t_rule_ctl;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic done;
    } t_div_sts;

endpackage
`default_nettype wire

// ===== rtl/abr_sra_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ABR source rate adjust request channel
// Valid/ready channel carrying one rate update request.
// ----------------------------------------------------------------------------
interface abr_sra_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic        cong_ind;
    logic        no_increase;
    logic        backward_notice;
    logic [26:0] explicit_rate;
    logic [31:0] now_slot;

    modport source (
        output valid, opcode, cong_ind, no_increase, backward_notice,
               explicit_rate, now_slot,
        input  ready
    );
    modport sink (
        input  valid, opcode, cong_ind, no_increase, backward_notice,
               explicit_rate, now_slot,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/abr_sra_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ABR source rate adjust result channel
// Valid/ready channel carrying the rate and slot interval of one request.
// ----------------------------------------------------------------------------
interface abr_sra_rsp_if;
    logic        valid;
    logic        ready;
    logic [26:0] allowed_rate;
    logic        send_enable;
    logic [29:0] slot_interval;
    logic [7:0]  interval_frac;
    logic        interval_changed;

    modport source (
        output valid, allowed_rate, send_enable, slot_interval, interval_frac,
               interval_changed,
        input  ready
    );
    modport sink (
        input  valid, allowed_rate, send_enable, slot_interval, interval_frac,
               interval_changed,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/abr_sra_rules.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ABR source rate adjust rule engine
// Holds ACR, the unacknowledged RM count and the last RM slot; applies the
// source rules in two steps per request.
// ----------------------------------------------------------------------------
module abr_sra_rules (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  abr_sra_pkg::t_cfg       i_cfg,
    input  abr_sra_pkg::t_item      i_item,
    input  abr_sra_pkg::t_rule_ctl  i_ctl,
    output logic [abr_sra_pkg::RATE_W-1:0] o_acr
);
    import abr_sra_pkg::*;

    logic [RATE_W-1:0] r_acr, n_acr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_last, n_last;

    logic [RATE_W-1:0] dec_ci;
    logic [RATE_W-1:0] dec_cdf;
    logic [RATE_W:0]   inc_sum;
    logic [SLOT_W-1:0] elapsed;

    assign dec_ci  = r_acr - (r_acr >> i_cfg.decrease_shift);
    assign dec_cdf = r_acr - (r_acr >> CDF_SHIFT);
    assign inc_sum = {1'b0, r_acr} + {1'b0, i_cfg.peak_rate >> i_cfg.increase_shift};
    assign elapsed = i_item.now_slot - r_last;

    always_comb begin
        n_acr  = r_acr;
        n_cnt  = r_cnt;
        n_last = r_last;
        if (i_ctl.phase_a) begin
            unique case (i_item.opcode)
                OP_CONNECT: begin
                    n_acr  = i_cfg.initial_rate;
                    n_cnt  = '0;
                    n_last = i_item.now_slot;
                end
                OP_BRM: begin
                    if (!i_item.backward_notice) begin
                        n_cnt = '0;
                    end
                    if (i_item.cong_ind) begin
                        n_acr = (dec_ci < i_cfg.min_rate) ? i_cfg.min_rate : dec_ci;
                    end else if (!i_item.no_increase) begin
                        n_acr = (inc_sum > {1'b0, i_cfg.peak_rate}) ? i_cfg.peak_rate
                                                                    : inc_sum[RATE_W-1:0];
                    end
                end
                OP_SENT: begin
                    // idle too long: fall back to the initial rate
                    if (elapsed > i_cfg.idle_limit_ticks && r_acr > i_cfg.initial_rate) begin
                        n_acr = i_cfg.initial_rate;
                    end
                    n_last = i_item.now_slot;
                end
                default: begin
                end
            endcase
        end else if (i_ctl.phase_b) begin
            unique case (i_item.opcode)
                OP_BRM: begin
                    // explicit rate cap
                    if (r_acr > i_item.explicit_rate &&
                        i_item.explicit_rate >= i_cfg.min_rate) begin
                        n_acr = i_item.explicit_rate;
                    end
                end
                OP_SENT: begin
                    if (r_cnt >= i_cfg.missing_rm_limit) begin
                        n_acr = (dec_cdf < i_cfg.min_rate) ? i_cfg.min_rate : dec_cdf;
                    end
                    if (r_cnt != '1) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acr  <= '0;
            r_cnt  <= '0;
            r_last <= '0;
        end else begin
            r_acr  <= n_acr;
            r_cnt  <= n_cnt;
            r_last <= n_last;
        end
    end

    assign o_acr = r_acr;

endmodule
`default_nettype wire

// ===== rtl/abr_sra_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ABR source rate adjust interval divider
// Restoring divider on one shared subtractor: integer quotient bit by bit,
// then eight fraction bits of (divisor - remainder) / divisor.
// ----------------------------------------------------------------------------
module abr_sra_div (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  abr_sra_pkg::t_div_ctl          i_ctl,
    input  wire [abr_sra_pkg::RATE_W-1:0]  i_dividend,
    input  wire [abr_sra_pkg::RATE_W-1:0]  i_divisor,
    output abr_sra_pkg::t_div_sts          o_sts,
    output logic [abr_sra_pkg::RATE_W-1:0] o_quot,
    output logic [abr_sra_pkg::FRAC_W-1:0] o_frac
);
    import abr_sra_pkg::*;

    localparam int STEP_W = $clog2(RATE_W);

    localparam logic [2:0] DV_IDLE = 3'd0;
    localparam logic [2:0] DV_QUOT = 3'd1;
    localparam logic [2:0] DV_PREP = 3'd2;
    localparam logic [2:0] DV_FRAC = 3'd3;
    localparam logic [2:0] DV_DONE = 3'd4;

    logic [2:0]        r_state;
    logic [STEP_W-1:0] r_step;
    logic [RATE_W-1:0] r_rem;
    logic [RATE_W-1:0] r_quo;
    logic [RATE_W-1:0] r_dvs;
    logic [FRAC_W-1:0] r_frac;
    logic              r_rem_zero;

    logic [RATE_W:0]   sub_a;
    logic [RATE_W:0]   sub_b;
    logic [RATE_W+1:0] sub_diff;
    logic              sub_ge;

    // shared subtractor, operands steered by the sequencer
    always_comb begin
        unique case (r_state)
            DV_QUOT: begin
                sub_a = {r_rem, r_quo[RATE_W-1]};
                sub_b = {1'b0, r_dvs};
            end
            DV_PREP: begin
                sub_a = {1'b0, r_dvs};
                sub_b = {1'b0, r_rem};
            end
            default: begin
                sub_a = {r_rem, 1'b0};
                sub_b = {1'b0, r_dvs};
            end
        endcase
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = ~sub_diff[RATE_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                DV_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= DV_QUOT;
                        r_step  <= STEP_W'(RATE_W - 1);
                    end
                end
                DV_QUOT: begin
                    if (r_step == '0) begin
                        r_state <= DV_PREP;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                DV_PREP: begin
                    r_state <= DV_FRAC;
                    r_step  <= STEP_W'(FRAC_W - 1);
                end
                DV_FRAC: begin
                    if (r_step == '0) begin
                        r_state <= DV_DONE;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                default: begin
                    r_state <= DV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            DV_IDLE: begin
                if (i_ctl.start) begin
                    r_quo <= i_dividend;
                    r_dvs <= i_divisor;
                    r_rem <= '0;
                end
            end
            DV_QUOT: begin
                r_rem <= sub_ge ? sub_diff[RATE_W-1:0] : sub_a[RATE_W-1:0];
                r_quo <= {r_quo[RATE_W-2:0], sub_ge};
            end
            DV_PREP: begin
                // an exact quotient gives a full fraction
                r_rem_zero <= (r_rem == '0);
                r_rem      <= sub_diff[RATE_W-1:0];
            end
            DV_FRAC: begin
                r_rem  <= sub_ge ? sub_diff[RATE_W-1:0] : sub_a[RATE_W-1:0];
                r_frac <= {r_frac[FRAC_W-2:0], sub_ge};
            end
            default: begin
            end
        endcase
    end

    assign o_sts.done = (r_state == DV_DONE);
    assign o_quot     = r_quo;
    assign o_frac     = r_rem_zero ? '1 : r_frac;

endmodule
`default_nettype wire

// ===== rtl/abr_source_rate_adjust.sv =====
`default_nettype none
// A request passes two rule steps, then 27 quotient steps, a preparation step
// and 8 fraction steps of one 28-bit subtractor before its result is registered.
// A new request is taken once the previous result sits in the output register.
// Reset (synchronous, active low): registers to defaults, ACR and counts to
// zero, held interval to all ones, no result pending.
// ----------------------------------------------------------------------------
// ABR source rate adjust
// Keeps the allowed cell rate of one ABR source and reports the link slot
// interval it implies.
// ----------------------------------------------------------------------------
module abr_source_rate_adjust (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [abr_sra_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [abr_sra_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    abr_sra_req_if.sink                        i_req,
    abr_sra_rsp_if.source                      o_rsp
);
    import abr_sra_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RULE_A = 3'd1;
    localparam logic [2:0] ST_RULE_B = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DWAIT  = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]        r_state;
    t_cfg              r_cfg;
    t_item             r_item;
    logic [IVAL_W-1:0] r_held;

    logic              r_out_valid;
    logic [RATE_W-1:0] r_out_rate;
    logic              r_out_send;
    logic [IVAL_W-1:0] r_out_ival;
    logic [FRAC_W-1:0] r_out_frac;
    logic              r_out_chg;

    t_rule_ctl         rule_ctl;
    t_div_ctl          div_ctl;
    t_div_sts          div_sts;
    logic [RATE_W-1:0] acr;
    logic [RATE_W-1:0] quot;
    logic [FRAC_W-1:0] frac;
    logic [IVAL_W-1:0] ival;
    logic              req_fire;
    logic              out_load;

    assign req_fire = i_req.valid && i_req.ready;
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || o_rsp.ready);

    assign rule_ctl.phase_a = (r_state == ST_RULE_A);
    assign rule_ctl.phase_b = (r_state == ST_RULE_B);
    assign div_ctl.start    = (r_state == ST_DSTART);

    abr_sra_rules u_rules (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (r_item),
        .i_ctl   (rule_ctl),
        .o_acr   (acr)
    );

    abr_sra_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (r_cfg.link_rate),
        .i_divisor  (acr),
        .o_sts      (div_sts),
        .o_quot     (quot),
        .o_frac     (frac)
    );

    // a zero rate saturates the interval
    assign ival = (acr == '0) ? SAT_INTERVAL : {{(IVAL_W-RATE_W){1'b0}}, quot};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_rate         <= RST_MIN_RATE;
            r_cfg.peak_rate        <= RST_PEAK_RATE;
            r_cfg.initial_rate     <= RST_INIT_RATE;
            r_cfg.link_rate        <= RST_LINK_RATE;
            r_cfg.increase_shift   <= RST_INC_SHIFT;
            r_cfg.decrease_shift   <= RST_DEC_SHIFT;
            r_cfg.missing_rm_limit <= RST_CRM;
            r_cfg.idle_limit_ticks <= RST_IDLE_LIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_RATE:  r_cfg.min_rate         <= i_cfg_data[RATE_W-1:0];
                CFG_PEAK_RATE: r_cfg.peak_rate        <= i_cfg_data[RATE_W-1:0];
                CFG_INIT_RATE: r_cfg.initial_rate     <= i_cfg_data[RATE_W-1:0];
                CFG_LINK_RATE: r_cfg.link_rate        <= i_cfg_data[RATE_W-1:0];
                CFG_INC_SHIFT: r_cfg.increase_shift   <= i_cfg_data[SHIFT_W-1:0];
                CFG_DEC_SHIFT: r_cfg.decrease_shift   <= i_cfg_data[SHIFT_W-1:0];
                CFG_CRM:       r_cfg.missing_rm_limit <= i_cfg_data[CNT_W-1:0];
                default:       r_cfg.idle_limit_ticks <= i_cfg_data[SLOT_W-1:0];
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE:   if (req_fire) r_state <= ST_RULE_A;
                ST_RULE_A: r_state <= ST_RULE_B;
                ST_RULE_B: r_state <= ST_DSTART;
                ST_DSTART: r_state <= ST_DWAIT;
                ST_DWAIT:  if (div_sts.done) r_state <= ST_OUT;
                ST_OUT:    if (out_load) r_state <= ST_IDLE;
                default:   r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_item.opcode          <= i_req.opcode;
            r_item.cong_ind        <= i_req.cong_ind;
            r_item.no_increase     <= i_req.no_increase;
            r_item.backward_notice <= i_req.backward_notice;
            r_item.explicit_rate   <= i_req.explicit_rate;
            r_item.now_slot        <= i_req.now_slot;
        end
    end

    // held interval and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_held      <= ival;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_rate <= acr;
            r_out_send <= (acr > STOP_RATE);
            r_out_ival <= ival;
            r_out_frac <= (acr == '0) ? '0 : frac;
            r_out_chg  <= (ival != r_held);
        end
    end

    assign i_req.ready            = (r_state == ST_IDLE);
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.allowed_rate     = r_out_rate;
    assign o_rsp.send_enable      = r_out_send;
    assign o_rsp.slot_interval    = r_out_ival;
    assign o_rsp.interval_frac    = r_out_frac;
    assign o_rsp.interval_changed = r_out_chg;

endmodule
`default_nettype wire
